// ----- src/ble_packet_crc_whiten_reverse_assert.svh -----
// Assertion macros for the packet CRC / whitening block.
`ifndef BLE_PACKET_CRC_WHITEN_REVERSE_ASSERT_SVH
`define BLE_PACKET_CRC_WHITEN_REVERSE_ASSERT_SVH

// cond must never hold at a clock edge outside reset
`define BCW_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// whenever a holds, b holds in the same cycle
`define BCW_ASSERT_IMPLY(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

`endif

// ----- src/bcw_pkg.sv -----
package bcw_pkg;

    localparam logic [23:0] CRC_POLY     = 24'h00065B;
    localparam logic [23:0] CRC_INIT_RST = 24'h555555;
    localparam logic [7:0]  WHITEN_FB    = 8'h88;

    // back-end word index within one queue entry
    localparam logic [1:0] WIDX_PAYLOAD = 2'd0;
    localparam logic [1:0] WIDX_CRC_HI  = 2'd1;
    localparam logic [1:0] WIDX_CRC_MID = 2'd2;
    localparam logic [1:0] WIDX_CRC_LO  = 2'd3;

    // one classified input word; crc_bytes[0] goes out first
    typedef struct packed {
        logic [7:0]      payload;
        logic            last;
        logic [2:0][7:0] crc_bytes;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [6:0] lfsr;
        logic [7:0] mask;
    } whiten_t;

    function automatic logic [7:0] rev8(input logic [7:0] a);
        logic [7:0] v;
        for (int i = 0; i < 8; i++)
        begin
            v[7 - i] = a[i];
        end
        return v;
    endfunction

    // LSB-first byte into the CRC, left-shifting register
    function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] d);
        logic [23:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[23] ^ d[i];
            c  = {c[22:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // eight LFSR steps: whitening mask and following LFSR state
    function automatic whiten_t whiten_step(input logic [6:0] s);
        logic [7:0] c;
        whiten_t    r;
        c      = {1'b0, s};
        r.mask = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c         = c ^ WHITEN_FB;
                r.mask[i] = 1'b1;
            end
            c = c >> 1;
        end
        r.lfsr = c[6:0];
        return r;
    endfunction

endpackage

// ----- src/bcw_front.sv -----
module bcw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [23:0]       cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_data,
    input  logic              in_last,
    input  logic [5:0]        in_chan,
    input  bcw_pkg::q_stat_t  q_stat,
    output logic              push,
    output bcw_pkg::q_entry_t entry
);
    import bcw_pkg::*;

    logic [23:0] crc_init_reg, crc_init_next;
    logic [23:0] crc_reg, crc_next;
    logic [6:0]  lfsr_reg, lfsr_next;
    logic        pkt_start_reg, pkt_start_next;

    logic [23:0] crc_cur, crc_upd;
    logic [6:0]  lfsr_cur;
    whiten_t     w0, w1, w2, w3;

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    // packet start reloads CRC seed and LFSR (channel with bit 6 set)
    assign crc_cur  = pkt_start_reg ? crc_init_reg : crc_reg;
    assign lfsr_cur = pkt_start_reg ? {1'b1, in_chan} : lfsr_reg;
    assign crc_upd  = crc_byte(crc_cur, in_data);
    assign w0       = whiten_step(lfsr_cur);
    assign w1       = whiten_step(w0.lfsr);
    assign w2       = whiten_step(w1.lfsr);
    assign w3       = whiten_step(w2.lfsr);

    // rev(rev(c) ^ m) == c ^ rev(m)
    always_comb
    begin
        entry.payload      = rev8(in_data ^ w0.mask);
        entry.last         = in_last;
        entry.crc_bytes[0] = crc_upd[23:16] ^ rev8(w1.mask);
        entry.crc_bytes[1] = crc_upd[15:8]  ^ rev8(w2.mask);
        entry.crc_bytes[2] = crc_upd[7:0]   ^ rev8(w3.mask);
    end

    always_comb
    begin
        crc_init_next  = cfg_we ? cfg_wdata : crc_init_reg;
        crc_next       = crc_reg;
        lfsr_next      = lfsr_reg;
        pkt_start_next = pkt_start_reg;
        if (push)
        begin
            crc_next       = crc_upd;
            lfsr_next      = w0.lfsr;
            pkt_start_next = in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_init_reg  <= CRC_INIT_RST;
            crc_reg       <= CRC_INIT_RST;
            lfsr_reg      <= '0;
            pkt_start_reg <= 1'b1;
        end
        else
        begin
            crc_init_reg  <= crc_init_next;
            crc_reg       <= crc_next;
            lfsr_reg      <= lfsr_next;
            pkt_start_reg <= pkt_start_next;
        end
    end

endmodule

// ----- src/bcw_queue.sv -----
module bcw_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bcw_pkg::q_entry_t wr_entry,
    input  logic              pop,
    output bcw_pkg::q_entry_t head,
    output bcw_pkg::q_stat_t  stat
);
    import bcw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    q_entry_t         store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head       = store[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/bcw_back.sv -----
module bcw_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bcw_pkg::q_entry_t head,
    input  bcw_pkg::q_stat_t  q_stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_last,
    output logic [1:0]        idx
);
    import bcw_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       load;

    // queue not empty and output register free or being drained this cycle
    assign load = !q_stat.empty && (!valid_reg || out_ready);
    assign pop  = load && ((idx_reg == WIDX_PAYLOAD && !head.last) || idx_reg == WIDX_CRC_LO);

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            last_next  = (idx_reg == WIDX_CRC_LO);
            idx_next   = pop ? WIDX_PAYLOAD : idx_reg + 1'b1;
            unique case (idx_reg)
                WIDX_PAYLOAD: byte_next = head.payload;
                WIDX_CRC_HI:  byte_next = head.crc_bytes[0];
                WIDX_CRC_MID: byte_next = head.crc_bytes[1];
                WIDX_CRC_LO:  byte_next = head.crc_bytes[2];
                default:      byte_next = head.payload;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= WIDX_PAYLOAD;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign idx       = idx_reg;

endmodule

// ----- src/ble_packet_crc_whiten_reverse.sv -----
// Advertising packet transmit path: CRC-24 plus data whitening, on-air bit order.
// Input stream (s_axis): one payload byte per word; tlast marks the final payload
//   byte of a packet; the channel index rides in tdata and is sampled only on the
//   first word of a packet (after reset or after a tlast word).
// Output stream (m_axis): one on-air byte per word, payload bytes first, then the
//   three CRC bytes high first; tlast is set on the last CRC byte only.
// Config: cfg_we/cfg_wdata writes the CRC seed; it is used from the next packet on.
// Front end does the whole CRC and LFSR update for a byte in the accept cycle and
// precomputes the whitened CRC bytes; back end serializes entries from a short queue.
// Path: an accepted word is written into the queue, then into the back-end output register.
// Throughput: one word per cycle both ways while m_axis_tready stays high; a tlast
//   word makes four output words, so the input backs up once per packet while the
//   back end sends the three CRC bytes.
// Reset: CRC seed back to 0x555555, queue and output register empty, next word
//   starts a packet.
// Receiver stall: the output word holds; the queue fills and s_axis_tready drops
//   when it is full.
`include "ble_packet_crc_whiten_reverse_assert.svh"

module ble_packet_crc_whiten_reverse #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [13:8] channel_number, [15:14] zero
    input  logic        s_axis_tlast,   // last_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // last_out
);
    import bcw_pkg::*;

    q_stat_t    q_stat;
    q_entry_t   q_wr_entry;
    q_entry_t   q_head;
    logic       q_push;
    logic       q_pop;
    logic [1:0] bk_idx;

    bcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata[7:0]),
        .in_last   (s_axis_tlast),
        .in_chan   (s_axis_tdata[13:8]),
        .q_stat    (q_stat),
        .push      (q_push),
        .entry     (q_wr_entry)
    );

    bcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    bcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .idx       (bk_idx)
    );

    // queue never written full or read empty
    `BCW_ASSERT_NEVER(a_q_overflow, q_push && q_stat.full, "queue write while full")
    `BCW_ASSERT_NEVER(a_q_underflow, q_pop && q_stat.empty, "queue read while empty")
    // mid CRC sequence the head must be a packet-closing entry
    `BCW_ASSERT_IMPLY(a_crc_head, bk_idx != WIDX_PAYLOAD, !q_stat.empty && q_head.last, "CRC sequence without last entry")
    // a pending tlast word means the CRC sequence has wrapped
    `BCW_ASSERT_IMPLY(a_last_wrap, m_axis_tvalid && m_axis_tlast, bk_idx == WIDX_PAYLOAD, "tlast with CRC sequence open")

endmodule
